### hdl/qws_pkg.sv
// ----------------------------------------------------------------------------
// qws_pkg
// Shared types and limits for the quoted word splitter: result kinds, the
// result bundle that one input byte produces, and the line/word limits.
// ----------------------------------------------------------------------------
package qws_pkg;

   // line and word limits
   localparam int MAX_LINE_BYTES = 4096;
   localparam int MAX_WORDS      = 32;
   localparam int MAX_WORD_BYTES = 256;

   // counter widths that follow from the limits
   localparam int LINE_LEN_W = $clog2(MAX_LINE_BYTES);
   localparam int WORD_CNT_W = $clog2(MAX_WORDS + 1);
   localparam int WORD_LEN_W = $clog2(MAX_WORD_BYTES);

   // results caused by one byte, and bundle queue depth
   localparam int MAX_RESULTS = 4;
   localparam int SLOT_W      = $clog2(MAX_RESULTS);
   localparam int RCOUNT_W    = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // result kind codes
   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_WEND   = 2'd1,
      KIND_ACCEPT = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   // one result word
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic        quoted;
   } result_type;

   // all results caused by one input byte, in order from slot 0
   typedef struct packed {
      logic [RCOUNT_W-1:0]              count;
      result_type [MAX_RESULTS-1:0]     slot;
   } bundle_type;

endpackage

### hdl/quoted_word_splitter_utf8_unit.sv
// ----------------------------------------------------------------------------
// quoted_word_splitter_utf8_unit
// Splits a command line, one byte per word, into bare and quoted words,
// decoding JSON escapes to UTF-8 and ending each line with accept or reject.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake            payload
//   req_      in    req_valid/req_stall  char_byte, end_of_line
//   rsp_      out   rsp_valid/rsp_stall  result_kind, out_byte,
//                                        word_was_quoted, last_of_run
//
// One byte a cycle is taken into the input register while req_stall is low;
// the scanner decodes it there and queues its 0 to 4 results as one bundle
// (4 bundles deep). Results leave one per cycle while rsp_stall is low, in
// slot order; bytes with no result never use the queue.
// Reset (synchronous) empties the queue and starts a fresh line.
// req_stall rises only while the input register holds a byte whose results
// find the queue full.
// ----------------------------------------------------------------------------
module quoted_word_splitter_utf8_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_word_was_quoted,
   output logic       rsp_last_of_run
);

   localparam int QPW = qws_pkg::QPTR_W;
   localparam int QCW = qws_pkg::QCOUNT_W;
   localparam int SW  = qws_pkg::SLOT_W;
   localparam int RCW = qws_pkg::RCOUNT_W;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_char_ff;
   logic              in_eol_ff;

   // bundle queue
   qws_pkg::bundle_type q_mem_ff [qws_pkg::QUEUE_DEPTH];
   logic [QPW-1:0]    wr_ff, wr_in;
   logic [QPW-1:0]    rd_ff, rd_in;
   logic [QCW-1:0]    qcnt_ff, qcnt_in;
   logic [SW-1:0]     sub_ff, sub_in;

   qws_pkg::bundle_type  bundle;
   qws_pkg::bundle_type  head;
   qws_pkg::result_type  head_res;
   logic              q_full;
   logic              fire;
   logic              push;
   logic              pop_word;
   logic              pop_bundle;
   logic              head_last;

   assign q_full    = (qcnt_ff == QCW'(qws_pkg::QUEUE_DEPTH));
   assign fire      = in_valid_ff && (bundle.count == '0 || !q_full);
   assign push      = fire && (bundle.count != '0);
   assign req_stall = in_valid_ff && !fire;

   qws_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .step_en     (fire),
      .char_byte   (in_char_ff),
      .end_of_line (in_eol_ff),
      .bundle      (bundle)
   );

   // output side: walk the head bundle one result at a time
   assign head       = q_mem_ff[rd_ff];
   assign head_res   = head.slot[sub_ff];
   assign head_last  = (RCW'(sub_ff) + RCW'(1) == head.count);
   assign rsp_valid  = (qcnt_ff != '0);
   assign pop_word   = rsp_valid && !rsp_stall;
   assign pop_bundle = pop_word && head_last;

   assign rsp_result_kind     = head_res.kind;
   assign rsp_out_byte        = head_res.data;
   assign rsp_word_was_quoted = head_res.quoted;
   assign rsp_last_of_run     = head_last;

   // next values
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      wr_in   = push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = pop_bundle ? rd_ff + 1'b1 : rd_ff;
      qcnt_in = qcnt_ff + QCW'(push) - QCW'(pop_bundle);
      sub_in  = sub_ff;
      if (pop_bundle) begin
         sub_in = '0;
      end else if (pop_word) begin
         sub_in = sub_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wr_ff       <= '0;
         rd_ff       <= '0;
         qcnt_ff     <= '0;
         sub_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ff       <= wr_in;
         rd_ff       <= rd_in;
         qcnt_ff     <= qcnt_in;
         sub_ff      <= sub_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_byte;
         in_eol_ff  <= req_end_of_line;
      end
      if (push) begin
         q_mem_ff[wr_ff] <= bundle;
      end
   end

endmodule

### hdl/qws_scan.sv
// ----------------------------------------------------------------------------
// qws_scan
// Line scanner: holds the per-line state, decodes one byte per step (bare
// words, quoted words with JSON escapes, \u surrogate pairs to UTF-8) and
// presents the bundle of results that byte causes.
// ----------------------------------------------------------------------------
module qws_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          char_byte,
   input  logic                end_of_line,
   output qws_pkg::bundle_type bundle
);

   localparam int LLW = qws_pkg::LINE_LEN_W;
   localparam int WCW = qws_pkg::WORD_CNT_W;
   localparam int WLW = qws_pkg::WORD_LEN_W;
   localparam int LSW = WLW + 3;
   localparam int RCW = qws_pkg::RCOUNT_W;

   // character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_DEL   = 8'h7f;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   typedef enum logic [3:0] {
      M_BETWEEN = 4'd0,
      M_BARE    = 4'd1,
      M_QUOTED  = 4'd2,
      M_ESC     = 4'd3,
      M_HEX_HI  = 4'd4,
      M_SUR_BSL = 4'd5,
      M_SUR_U   = 4'd6,
      M_HEX_LO  = 4'd7,
      M_CLOSED  = 4'd8
   } mode_type;

   // state registers
   mode_type          mode_ff,   mode_in;
   logic [15:0]       acc_ff,    acc_in;
   logic [1:0]        dig_ff,    dig_in;
   logic [9:0]        sur_ff,    sur_in;
   logic [WLW-1:0]    wlen_ff,   wlen_in;
   logic [WCW-1:0]    wcnt_ff,   wcnt_in;
   logic [LLW-1:0]    llen_ff,   llen_in;
   logic              failed_ff, failed_in;

   // decode intermediates
   logic              hex_ok;
   logic [3:0]        hex_dig;
   logic [15:0]       hex_new;
   logic [20:0]       cp;
   logic              cp_bad;
   logic [7:0]        u8_b [4];
   logic [2:0]        u8_n;
   logic              bare_ok;
   logic [LLW:0]      lsum;
   logic [LSW-1:0]    wsum;

   logic              ok;
   logic              want_add;
   logic [2:0]        add_k;
   logic [7:0]        add_b [4];
   logic [RCW-1:0]    dn;
   logic              wend, wq, accept, reject;

   // hex digit value
   always_comb begin
      hex_ok  = 1'b1;
      hex_dig = 4'd0;
      if (char_byte >= 8'h30 && char_byte <= 8'h39) begin
         hex_dig = char_byte[3:0];
      end else if ((char_byte >= 8'h61 && char_byte <= 8'h66) ||
                   (char_byte >= 8'h41 && char_byte <= 8'h46)) begin
         hex_dig = char_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign hex_new = {acc_ff[11:0], hex_dig};
   assign bare_ok = !(char_byte < CH_SPACE || char_byte == CH_DEL ||
                      char_byte == CH_QUOTE || char_byte == CH_BSL);

   // code point: plain \uXXXX or combined surrogate pair
   assign cp = (mode_ff == M_HEX_LO) ? (21'h010000 + {1'b0, sur_ff, hex_new[9:0]})
                                     : {5'd0, hex_new};
   assign cp_bad = (cp == 21'd0) || (cp > 21'h10ffff) ||
                   (cp >= 21'h00d800 && cp <= 21'h00dfff);

   // UTF-8 encoding of the code point
   always_comb begin
      u8_b[0] = 8'h00;
      u8_b[1] = 8'h00;
      u8_b[2] = 8'h00;
      u8_b[3] = 8'h00;
      if (cp <= 21'h00007f) begin
         u8_b[0] = cp[7:0];
         u8_n    = 3'd1;
      end else if (cp <= 21'h0007ff) begin
         u8_b[0] = 8'hc0 | {3'd0, cp[10:6]};
         u8_b[1] = 8'h80 | {2'd0, cp[5:0]};
         u8_n    = 3'd2;
      end else if (cp <= 21'h00ffff) begin
         u8_b[0] = 8'he0 | {4'd0, cp[15:12]};
         u8_b[1] = 8'h80 | {2'd0, cp[11:6]};
         u8_b[2] = 8'h80 | {2'd0, cp[5:0]};
         u8_n    = 3'd3;
      end else begin
         u8_b[0] = 8'hf0 | {5'd0, cp[20:18]};
         u8_b[1] = 8'h80 | {2'd0, cp[17:12]};
         u8_b[2] = 8'h80 | {2'd0, cp[11:6]};
         u8_b[3] = 8'h80 | {2'd0, cp[5:0]};
         u8_n    = 3'd4;
      end
   end

   // next state and results for the byte in hand
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      dig_in    = dig_ff;
      sur_in    = sur_ff;
      wlen_in   = wlen_ff;
      wcnt_in   = wcnt_ff;
      llen_in   = llen_ff;
      failed_in = failed_ff;
      ok        = 1'b1;
      want_add  = 1'b0;
      add_k     = 3'd1;
      add_b[0]  = char_byte;
      add_b[1]  = 8'h00;
      add_b[2]  = 8'h00;
      add_b[3]  = 8'h00;
      dn        = '0;
      wend      = 1'b0;
      wq        = 1'b0;
      accept    = 1'b0;
      reject    = 1'b0;
      lsum      = {1'b0, llen_ff} + {{LLW{1'b0}}, 1'b1};
      wsum      = '0;

      if (!failed_ff) begin
         // line length limit
         if (lsum >= (LLW+1)'(qws_pkg::MAX_LINE_BYTES)) begin
            ok = 1'b0;
         end else begin
            llen_in = lsum[LLW-1:0];
         end

         if (ok) begin
            case (mode_ff)
               M_BETWEEN: begin
                  if (char_byte != CH_SPACE) begin
                     if (wcnt_ff >= WCW'(qws_pkg::MAX_WORDS)) begin
                        ok = 1'b0;
                     end else begin
                        wcnt_in = wcnt_ff + 1'b1;
                        wlen_in = '0;
                        if (char_byte == CH_QUOTE) begin
                           mode_in = M_QUOTED;
                        end else if (!bare_ok) begin
                           ok = 1'b0;
                        end else begin
                           mode_in  = M_BARE;
                           want_add = 1'b1;
                        end
                     end
                  end
               end
               M_BARE: begin
                  if (char_byte == CH_SPACE) begin
                     wend    = 1'b1;
                     mode_in = M_BETWEEN;
                  end else if (!bare_ok) begin
                     ok = 1'b0;
                  end else begin
                     want_add = 1'b1;
                  end
               end
               M_QUOTED: begin
                  if (char_byte == CH_QUOTE) begin
                     wend    = 1'b1;
                     wq      = 1'b1;
                     mode_in = M_CLOSED;
                  end else if (char_byte < CH_SPACE) begin
                     ok = 1'b0;
                  end else if (char_byte == CH_BSL) begin
                     mode_in = M_ESC;
                  end else begin
                     want_add = 1'b1;
                  end
               end
               M_ESC: begin
                  mode_in  = M_QUOTED;
                  want_add = 1'b1;
                  case (char_byte)
                     CH_QUOTE: add_b[0] = CH_QUOTE;
                     CH_BSL:   add_b[0] = CH_BSL;
                     CH_B:     add_b[0] = 8'h08;
                     CH_F:     add_b[0] = 8'h0c;
                     CH_N:     add_b[0] = 8'h0a;
                     CH_R:     add_b[0] = 8'h0d;
                     CH_T:     add_b[0] = 8'h09;
                     CH_U: begin
                        want_add = 1'b0;
                        mode_in  = M_HEX_HI;
                        acc_in   = 16'd0;
                        dig_in   = 2'd0;
                     end
                     default: begin
                        want_add = 1'b0;
                        ok       = 1'b0;
                     end
                  endcase
               end
               M_HEX_HI, M_HEX_LO: begin
                  if (!hex_ok) begin
                     ok = 1'b0;
                  end else begin
                     acc_in = hex_new;
                     if (dig_ff != 2'd3) begin
                        dig_in = dig_ff + 2'd1;
                     end else begin
                        dig_in = 2'd0;
                        if (mode_ff == M_HEX_HI &&
                            hex_new >= 16'hd800 && hex_new <= 16'hdbff) begin
                           // high surrogate: wait for the low half
                           sur_in  = hex_new[9:0];
                           mode_in = M_SUR_BSL;
                        end else if (mode_ff == M_HEX_LO &&
                                     (hex_new < 16'hdc00 || hex_new > 16'hdfff)) begin
                           ok = 1'b0;
                        end else if (cp_bad) begin
                           ok = 1'b0;
                        end else begin
                           mode_in  = M_QUOTED;
                           want_add = 1'b1;
                           add_k    = u8_n;
                           add_b    = u8_b;
                        end
                     end
                  end
               end
               M_SUR_BSL: begin
                  if (char_byte != CH_BSL) begin
                     ok = 1'b0;
                  end else begin
                     mode_in = M_SUR_U;
                  end
               end
               M_SUR_U: begin
                  if (char_byte != CH_U) begin
                     ok = 1'b0;
                  end else begin
                     mode_in = M_HEX_LO;
                     acc_in  = 16'd0;
                     dig_in  = 2'd0;
                  end
               end
               M_CLOSED: begin
                  if (char_byte != CH_SPACE) begin
                     ok = 1'b0;
                  end else begin
                     mode_in = M_BETWEEN;
                  end
               end
               default: ok = 1'b0;
            endcase
         end

         // word length limit on decoded bytes
         if (ok && want_add) begin
            wsum = LSW'(wlen_in) + LSW'(add_k);
            if (wsum >= LSW'(qws_pkg::MAX_WORD_BYTES)) begin
               ok = 1'b0;
            end else begin
               wlen_in = wsum[WLW-1:0];
               dn      = RCW'(add_k);
            end
         end

         // end of line verdict
         if (ok && end_of_line) begin
            if (mode_in == M_BARE) begin
               wend   = 1'b1;
               accept = 1'b1;
            end else if (mode_in == M_CLOSED) begin
               accept = 1'b1;
            end else if (mode_in == M_BETWEEN && wcnt_in != '0) begin
               accept = 1'b1;
            end else begin
               ok = 1'b0;
            end
         end

         if (!ok) begin
            reject    = 1'b1;
            failed_in = 1'b1;
         end
      end

      // end of line starts a fresh line
      if (end_of_line) begin
         mode_in   = M_BETWEEN;
         acc_in    = 16'd0;
         dig_in    = 2'd0;
         sur_in    = 10'd0;
         wlen_in   = '0;
         wcnt_in   = '0;
         llen_in   = '0;
         failed_in = 1'b0;
      end
   end

   // result bundle: data bytes, then word end, then line verdict
   always_comb begin
      bundle = '0;
      if (reject) begin
         bundle.count          = RCW'(1);
         bundle.slot[0].kind   = qws_pkg::KIND_REJECT;
      end else begin
         bundle.count = dn + RCW'(wend) + RCW'(accept);
         for (int i = 0; i < qws_pkg::MAX_RESULTS; i++) begin
            if (RCW'(i) < dn) begin
               bundle.slot[i].kind = qws_pkg::KIND_DATA;
               bundle.slot[i].data = add_b[i];
            end else if (wend && RCW'(i) == dn) begin
               bundle.slot[i].kind   = qws_pkg::KIND_WEND;
               bundle.slot[i].quoted = wq;
            end else if (accept && RCW'(i) == dn + RCW'(wend)) begin
               bundle.slot[i].kind = qws_pkg::KIND_ACCEPT;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_BETWEEN;
         acc_ff    <= 16'd0;
         dig_ff    <= 2'd0;
         sur_ff    <= 10'd0;
         wlen_ff   <= '0;
         wcnt_ff   <= '0;
         llen_ff   <= '0;
         failed_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         dig_ff    <= dig_in;
         sur_ff    <= sur_in;
         wlen_ff   <= wlen_in;
         wcnt_ff   <= wcnt_in;
         llen_ff   <= llen_in;
         failed_ff <= failed_in;
      end
   end

endmodule

### tb/sv/tb_quoted_word_splitter_utf8_unit.sv
// ----------------------------------------------------------------------------
// tb_quoted_word_splitter_utf8_unit
// Self-checking bench for the quoted word splitter. A short table of hand-made
// lines is followed by random lines: mostly well-formed bare and quoted args
// with escapes and surrogate pairs, plus broken lines and limit-sized lines.
// Every word sent is run through a local scanner model and each result word
// is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_quoted_word_splitter_utf8_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 330;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int N_DIRECTED     = 25;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   // scanner position within a line
   typedef enum logic [3:0] {
      SC_BETWEEN, SC_BARE, SC_QUOTED, SC_ESC, SC_HEX_HI,
      SC_SUR_BSL, SC_SUR_U, SC_HEX_LO, SC_CLOSED
   } scan_state_type;

   // how a directed row is checked
   typedef enum logic [1:0] {CHK_PREDICT, CHK_QUIET, CHK_REJECT} row_check_type;

   // ways of breaking a random line
   typedef enum int {FLT_FLIP, FLT_CTRL, FLT_CUT, FLT_TOKEN} fault_type;

   typedef struct packed {
      qws_pkg::kind_type kind;
      logic [7:0]        data;
      logic              quoted;
      logic              last;
   } rsp_word_type;

   typedef struct {
      logic [7:0]    ch;
      logic          eol;
      row_check_type chk;
   } row_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_byte   = 8'h20;
   logic       req_end_of_line = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_word_was_quoted;
   logic       rsp_last_of_run;

   // scanner model state
   scan_state_type sc_state;
   logic [15:0] hex_acc;
   logic [1:0]  hex_cnt;
   logic [9:0]  hi_sur;
   logic [8:0]  word_len;
   logic [5:0]  word_cnt;
   logic [12:0] line_len;
   logic        line_dead;

   rsp_word_type step_out[$];
   rsp_word_type pending_rsp[$];
   logic [7:0]  line_q[$];

   int          fault_count = 0;
   int          idle_cycles = 0;
   int          stall_left  = 0;
   int          idle_pct    = 0;
   int          stall_pct   = 0;
   bit          calm        = 1'b0;

   string       esc_set = "\"\\bfnrt";
   string       broken_arg [8] = '{
      "\"\\u0000\"", "\"\\udc12\"", "\"\\ud812x\"", "\"\\ud812\\x\"",
      "\"\\ud812\\u0041\"", "\"\\q\"", "\"\\u12g4\"", "\"ab\"c"
   };

   // hand-made lines: extremes, a surrogate pair, bad escape, glued quote
   row_type directed_rows [N_DIRECTED] = '{
      '{8'hFF, 1'b0, CHK_PREDICT}, '{CH_SPACE, 1'b0, CHK_PREDICT},
      '{8'h01, 1'b1, CHK_REJECT},
      '{CH_SPACE, 1'b1, CHK_REJECT},
      '{CH_QUOTE, 1'b0, CHK_PREDICT}, '{CH_BSL, 1'b0, CHK_PREDICT},
      '{"u", 1'b0, CHK_PREDICT}, '{"D", 1'b0, CHK_PREDICT},
      '{"8", 1'b0, CHK_PREDICT}, '{"3", 1'b0, CHK_PREDICT},
      '{"D", 1'b0, CHK_PREDICT}, '{CH_BSL, 1'b0, CHK_PREDICT},
      '{"u", 1'b0, CHK_PREDICT}, '{"d", 1'b0, CHK_PREDICT},
      '{"e", 1'b0, CHK_PREDICT}, '{"0", 1'b0, CHK_PREDICT},
      '{"0", 1'b0, CHK_PREDICT}, '{CH_QUOTE, 1'b1, CHK_PREDICT},
      '{CH_QUOTE, 1'b0, CHK_PREDICT}, '{CH_BSL, 1'b0, CHK_PREDICT},
      '{"x", 1'b0, CHK_REJECT}, '{"z", 1'b1, CHK_QUIET},
      '{CH_QUOTE, 1'b0, CHK_PREDICT}, '{CH_QUOTE, 1'b0, CHK_PREDICT},
      '{"b", 1'b1, CHK_REJECT}
   };

   quoted_word_splitter_utf8_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_byte       (req_char_byte),
      .req_end_of_line     (req_end_of_line),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_word_was_quoted (rsp_word_was_quoted),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic void clear_line_state();
      sc_state  = SC_BETWEEN;
      hex_acc   = '0;
      hex_cnt   = '0;
      hi_sur    = '0;
      word_len  = '0;
      word_cnt  = '0;
      line_len  = '0;
      line_dead = 1'b0;
   endfunction

   function automatic void emit(input qws_pkg::kind_type k, input logic [7:0] d,
                                input logic q);
      if (step_out.size() < qws_pkg::MAX_RESULTS) step_out.push_back('{k, d, q, 1'b0});
   endfunction

   // appends decoded bytes to the current arg; 0 if it would grow too long
   function automatic bit put_bytes(input logic [7:0] b [4], input int n);
      int i;
      if (word_len + n >= qws_pkg::MAX_WORD_BYTES) return 1'b0;
      for (i = 0; i < n; i++) emit(qws_pkg::KIND_DATA, b[i], 1'b0);
      word_len += n;
      return 1'b1;
   endfunction

   function automatic bit put_byte(input logic [7:0] c);
      logic [7:0] b [4];
      b[0] = c;
      return put_bytes(b, 1);
   endfunction

   // UTF-8 encoding of one code point
   function automatic bit put_code_point(input logic [20:0] v);
      logic [7:0] b [4];
      int         n;
      if (v == 0 || v > 21'h10FFFF || (v >= 21'h0D800 && v <= 21'h0DFFF)) return 1'b0;
      if (v <= 21'h7F) begin
         b[0] = v[7:0];
         n = 1;
      end else if (v <= 21'h7FF) begin
         b[0] = {3'b110, v[10:6]};
         b[1] = {2'b10, v[5:0]};
         n = 2;
      end else if (v <= 21'hFFFF) begin
         b[0] = {4'b1110, v[15:12]};
         b[1] = {2'b10, v[11:6]};
         b[2] = {2'b10, v[5:0]};
         n = 3;
      end else begin
         b[0] = {5'b11110, v[20:18]};
         b[1] = {2'b10, v[17:12]};
         b[2] = {2'b10, v[11:6]};
         b[3] = {2'b10, v[5:0]};
         n = 4;
      end
      return put_bytes(b, n);
   endfunction

   function automatic bit bare_byte_ok(input logic [7:0] c);
      return !(c < CH_SPACE || c == CH_DEL || c == CH_QUOTE || c == CH_BSL);
   endfunction

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   // one byte through the scanner; 0 rejects the line
   function automatic bit scan_byte(input logic [7:0] c);
      int         d;
      logic [7:0] esc;
      case (sc_state)
         SC_BETWEEN: begin
            if (c == CH_SPACE) return 1'b1;
            if (word_cnt >= qws_pkg::MAX_WORDS) return 1'b0;
            word_cnt++;
            word_len = '0;
            if (c == CH_QUOTE) begin
               sc_state = SC_QUOTED;
               return 1'b1;
            end
            if (!bare_byte_ok(c)) return 1'b0;
            sc_state = SC_BARE;
            return put_byte(c);
         end
         SC_BARE: begin
            if (c == CH_SPACE) begin
               emit(qws_pkg::KIND_WEND, 8'h00, 1'b0);
               sc_state = SC_BETWEEN;
               return 1'b1;
            end
            if (!bare_byte_ok(c)) return 1'b0;
            return put_byte(c);
         end
         SC_QUOTED: begin
            if (c == CH_QUOTE) begin
               emit(qws_pkg::KIND_WEND, 8'h00, 1'b1);
               sc_state = SC_CLOSED;
               return 1'b1;
            end
            if (c < CH_SPACE) return 1'b0;
            if (c == CH_BSL) begin
               sc_state = SC_ESC;
               return 1'b1;
            end
            return put_byte(c);
         end
         SC_ESC: begin
            sc_state = SC_QUOTED;
            case (c)
               CH_QUOTE: esc = CH_QUOTE;
               CH_BSL:   esc = CH_BSL;
               "b":      esc = 8'h08;
               "f":      esc = 8'h0C;
               "n":      esc = 8'h0A;
               "r":      esc = 8'h0D;
               "t":      esc = 8'h09;
               "u": begin
                  sc_state = SC_HEX_HI;
                  hex_acc  = '0;
                  hex_cnt  = '0;
                  return 1'b1;
               end
               default: return 1'b0;
            endcase
            return put_byte(esc);
         end
         SC_HEX_HI, SC_HEX_LO: begin
            d = hex_digit(c);
            if (d < 0) return 1'b0;
            hex_acc = {hex_acc[11:0], d[3:0]};
            if (hex_cnt != 2'd3) begin
               hex_cnt++;
               return 1'b1;
            end
            hex_cnt = '0;
            if (sc_state == SC_HEX_HI) begin
               // high surrogate waits for its partner
               if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                  hi_sur   = hex_acc[9:0];
                  sc_state = SC_SUR_BSL;
                  return 1'b1;
               end
               sc_state = SC_QUOTED;
               return put_code_point({5'b0, hex_acc});
            end
            if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) return 1'b0;
            sc_state = SC_QUOTED;
            return put_code_point(21'h10000 + {hi_sur, hex_acc[9:0]});
         end
         SC_SUR_BSL: begin
            if (c != CH_BSL) return 1'b0;
            sc_state = SC_SUR_U;
            return 1'b1;
         end
         SC_SUR_U: begin
            if (c != "u") return 1'b0;
            sc_state = SC_HEX_LO;
            hex_acc  = '0;
            hex_cnt  = '0;
            return 1'b1;
         end
         SC_CLOSED: begin
            if (c != CH_SPACE) return 1'b0;
            sc_state = SC_BETWEEN;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // results of one accepted word, left in step_out
   function automatic void predict_word(input logic [7:0] c, input logic eol);
      bit ok;
      step_out.delete();
      if (line_dead) begin
         if (eol) clear_line_state();
         return;
      end
      ok = 1'b1;
      if (line_len + 1 >= qws_pkg::MAX_LINE_BYTES) ok = 1'b0;
      else line_len++;
      if (ok) ok = scan_byte(c);
      if (ok && eol) begin
         if (sc_state == SC_BARE) begin
            emit(qws_pkg::KIND_WEND, 8'h00, 1'b0);
            emit(qws_pkg::KIND_ACCEPT, 8'h00, 1'b0);
         end else if (sc_state == SC_CLOSED) begin
            emit(qws_pkg::KIND_ACCEPT, 8'h00, 1'b0);
         end else if (sc_state == SC_BETWEEN && word_cnt != 0) begin
            emit(qws_pkg::KIND_ACCEPT, 8'h00, 1'b0);
         end else begin
            ok = 1'b0;
         end
      end
      // a reject voids everything else from this word
      if (!ok) begin
         step_out.delete();
         emit(qws_pkg::KIND_REJECT, 8'h00, 1'b0);
         line_dead = 1'b1;
      end
      if (eol) clear_line_state();
      if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------ line maker

   function automatic void push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endfunction

   function automatic void push_hex16(input logic [15:0] v);
      logic [3:0] nib;
      int         i;
      for (i = 3; i >= 0; i--) begin
         nib = v[i*4 +: 4];
         if (nib < 10) line_q.push_back(8'(8'h30 + nib));
         else if ($urandom_range(0, 1)) line_q.push_back(8'(8'h57 + nib));
         else line_q.push_back(8'(8'h37 + nib));
      end
   endfunction

   function automatic void push_u_escape(input logic [15:0] v);
      line_q.push_back(CH_BSL);
      line_q.push_back("u");
      push_hex16(v);
   endfunction

   function automatic void push_pair();
      push_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
      push_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
   endfunction

   function automatic logic [7:0] rand_bare_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(8'h21, 8'hFF));
      while (!bare_byte_ok(c));
      return c;
   endfunction

   function automatic logic [7:0] rand_quoted_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(8'h20, 8'hFF));
      while (c == CH_QUOTE || c == CH_BSL);
      return c;
   endfunction

   function automatic void push_bare_arg(input int n);
      repeat (n) line_q.push_back(rand_bare_byte());
   endfunction

   function automatic void push_quoted_arg(input int n_parts);
      logic [15:0] cp;
      line_q.push_back(CH_QUOTE);
      repeat (n_parts) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: line_q.push_back(rand_quoted_byte());
            4, 5: begin
               line_q.push_back(CH_BSL);
               line_q.push_back(esc_set[$urandom_range(0, 6)]);
            end
            6, 7: begin
               do cp = 16'($urandom_range(1, 16'hFFFF));
               while (cp >= 16'hD800 && cp <= 16'hDFFF);
               push_u_escape(cp);
            end
            8: push_pair();
            default: push_u_escape(16'($urandom_range(1, 16'h7FF)));
         endcase
      end
      line_q.push_back(CH_QUOTE);
   endfunction

   // n single-byte args separated by one space
   function automatic void push_arg_list(input int n);
      int i;
      for (i = 0; i < n; i++) begin
         if (i != 0) line_q.push_back(CH_SPACE);
         line_q.push_back(rand_bare_byte());
      end
   endfunction

   function automatic void inject_fault();
      int pos;
      pos = $urandom_range(0, line_q.size() - 1);
      case (fault_type'($urandom_range(FLT_FLIP, FLT_TOKEN)))
         FLT_FLIP: line_q[pos] = 8'($urandom_range(1, 255));
         FLT_CTRL: line_q.insert(pos, 8'($urandom_range(1, 8'h1F)));
         FLT_CUT:  if (line_q.size() > 1) void'(line_q.pop_back());
         FLT_TOKEN: begin
            line_q.push_back(CH_SPACE);
            push_text(broken_arg[$urandom_range(0, 7)]);
         end
      endcase
   endfunction

   function automatic void build_ordinary_line();
      int n_args;
      int i;
      int roll;
      n_args = $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) line_q.push_back(CH_SPACE);
      for (i = 0; i < n_args; i++) begin
         if (i != 0) repeat ($urandom_range(1, 2)) line_q.push_back(CH_SPACE);
         if ($urandom_range(0, 1)) push_bare_arg($urandom_range(1, 6));
         else push_quoted_arg($urandom_range(0, 5));
      end
      if ($urandom_range(0, 4) == 0) line_q.push_back(CH_SPACE);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         // pure noise
         line_q.delete();
         repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(1, 255)));
      end else if (roll < 30) begin
         inject_fault();
      end
   endfunction

   // ------------------------------------------------------------ driving

   task automatic send_word(input logic [7:0] c, input logic eol, input row_check_type chk);
      int gap;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_byte   <= c;
      req_end_of_line <= eol;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(c, eol);
      case (chk)
         CHK_PREDICT: foreach (step_out[i]) pending_rsp.push_back(step_out[i]);
         CHK_REJECT:  pending_rsp.push_back('{qws_pkg::KIND_REJECT, 8'h00, 1'b0, 1'b1});
         default: ;
      endcase
   endtask

   task automatic send_line();
      int i;
      for (i = 0; i < line_q.size(); i++)
         send_word(line_q[i], i == line_q.size() - 1, CHK_PREDICT);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // random stall bursts on the result side
   always @(posedge clock) begin
      if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(1, 10);
         rsp_stall  <= 1'b1;
      end
   end

   // ------------------------------------------------------------ checking

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result word with nothing expected: kind %0d byte %0h",
                   rsp_result_kind, rsp_out_byte);
            fault_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("result_kind", want.kind, rsp_result_kind);
            check_field("out_byte", want.data, rsp_out_byte);
            check_field("word_was_quoted", want.quoted, rsp_word_was_quoted);
            check_field("last_of_run", want.last, rsp_last_of_run);
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $error("no handshake for %0d cycles, %0d results outstanding",
                WATCHDOG_LIMIT, pending_rsp.size());
         $display("** quoted_word_splitter_utf8_unit: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------ stimulus

   initial begin
      int line_no;
      int random_items;
      clear_line_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      idle_pct  = 25;
      stall_pct = 25;
      foreach (directed_rows[r])
         send_word(directed_rows[r].ch, directed_rows[r].eol, directed_rows[r].chk);
      hold_until_drained();

      // random lines, with the word count limit cases early on
      line_no      = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         line_q.delete();
         case (line_no)
            1: push_arg_list(qws_pkg::MAX_WORDS);
            2: push_arg_list(qws_pkg::MAX_WORDS + 1);
            default: build_ordinary_line();
         endcase
         random_items += line_q.size();
         if (random_items >= RANDOM_ITEMS * 4 / 5) calm = 1'b1;
         if (calm) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = 20 * $urandom_range(0, 2);
            stall_pct = 20 * $urandom_range(0, 2);
         end
         send_line();
         if (line_no == 12) hold_until_drained();
         line_no++;
      end

      // wind down
      calm = 1'b1;
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_rsp.size() == 0)
         $display("** quoted_word_splitter_utf8_unit: PASSED **");
      else
         $display("** quoted_word_splitter_utf8_unit: FAILED **");
      $finish;
   end

endmodule
